[sv/bfras_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfras_pkg
// Shared constants and types for the byte-framed register access slave.
// ----------------------------------------------------------------------------
package bfras_pkg;

    typedef logic [7:0] byte_t;

    localparam int REG_COUNT = 16;
    localparam int MAX_BURST = 16;
    localparam int BURST_LIMIT = (REG_COUNT < MAX_BURST) ? REG_COUNT : MAX_BURST;

    localparam int ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int LEN_W  = $clog2(BURST_LIMIT + 1);

    localparam logic [8:0]       REG_COUNT_EXT   = 9'(REG_COUNT);
    localparam logic [7:0]       BURST_LIMIT_B   = 8'(BURST_LIMIT);
    localparam logic [LEN_W-1:0] BURST_LIMIT_LEN = LEN_W'(BURST_LIMIT);

    localparam byte_t SYNC_BYTE = 8'hA5;

    localparam logic [6:0] ID_RESET = 7'd3;

    localparam logic [2:0] ADDR_DEVICE_IDENTITY = 3'd0;

endpackage : bfras_pkg
`default_nettype wire

[sv/byte_framed_register_access_slave_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// byte_framed_register_access_slave_unit
// Slave for a byte-framed register protocol: sync, header, address, length,
// then write data or a read reply streamed from a 16 x 8 register memory.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                              | payload
//  ---------+-----+--------------------------------------+------------------
//  rx       | in  | s_tvalid s_tready s_tdata            | rx_byte
//  tx       | out | m_tvalid m_tready m_tdata m_tlast    | tx_byte, last_byte
//  config   | in  | psel penable pwrite paddr pwdata ... | device_identity
//
//  s_tready is high whenever no reply runs.
//  A read reply goes out byte by byte and waits while the output register
//  is full: each byte is one registered read of the register memory and
//  one load of the output register, which holds it until m_tready takes it.
//  After reset all registers read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module byte_framed_register_access_slave_unit
    import bfras_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] tx_byte
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_ADDRESS = 3'd2;
    localparam logic [2:0] PH_LENGTH  = 3'd3;
    localparam logic [2:0] PH_WDATA   = 3'd4;

    localparam logic [1:0] CTL_IDLE    = 2'd0;
    localparam logic [1:0] CTL_RD_ADDR = 2'd1;
    localparam logic [1:0] CTL_RD_DATA = 2'd2;

    logic [6:0]       device_identity_reg;
    logic [2:0]       phase_reg, phase_next;
    logic             write_mode_reg, write_mode_next;
    byte_t            next_address_reg, next_address_next;
    logic             address_past_reg, address_past_next;
    byte_t            bytes_left_reg, bytes_left_next;
    logic [1:0]       ctl_reg, ctl_next;
    logic [8:0]       rd_addr_reg, rd_addr_next;
    logic [LEN_W-1:0] rd_count_reg, rd_count_next;
    logic             m_tvalid_reg, m_tvalid_next;
    byte_t            m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;

    byte_t            mem [REG_COUNT];
    logic [REG_COUNT-1:0] entry_valid_reg;
    byte_t            mem_rdata_reg;
    logic             mem_rvalid_reg;

    logic             s_accept;
    logic             cfg_write;
    logic             mem_we;
    logic             out_free;
    logic             wr_in_range;
    logic [LEN_W-1:0] rd_len;

    assign s_tready  = (ctl_reg == CTL_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign wr_in_range = !address_past_reg && ({1'b0, next_address_reg} < REG_COUNT_EXT);
    assign mem_we      = s_accept && (phase_reg == PH_WDATA) && wr_in_range;
    assign rd_len      = (s_tdata > BURST_LIMIT_B) ? BURST_LIMIT_LEN : LEN_W'(s_tdata);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ADDR_DEVICE_IDENTITY[2])
        begin
            prdata = {25'd0, device_identity_reg};
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        write_mode_next   = write_mode_reg;
        next_address_next = next_address_reg;
        address_past_next = address_past_reg;
        bytes_left_next   = bytes_left_reg;
        ctl_next          = ctl_reg;
        rd_addr_next      = rd_addr_reg;
        rd_count_next     = rd_count_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tlast_next      = m_tlast_reg;

        unique case (ctl_reg)
            CTL_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            if (s_tdata[7:1] == device_identity_reg)
                            begin
                                write_mode_next = s_tdata[0];
                                phase_next      = PH_ADDRESS;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_ADDRESS:
                        begin
                            next_address_next = s_tdata;
                            address_past_next = 1'b0;
                            phase_next        = PH_LENGTH;
                        end
                        PH_LENGTH:
                        begin
                            if (write_mode_reg)
                            begin
                                bytes_left_next = s_tdata;
                                phase_next      = (s_tdata != 8'd0) ? PH_WDATA : PH_HUNT;
                            end
                            else
                            begin
                                bytes_left_next = 8'd0;
                                phase_next      = PH_HUNT;
                                rd_addr_next    = {1'b0, next_address_reg};
                                rd_count_next   = rd_len;
                                if (rd_len != '0)
                                begin
                                    ctl_next = CTL_RD_ADDR;
                                end
                            end
                        end
                        PH_WDATA:
                        begin
                            if (next_address_reg == 8'hFF)
                            begin
                                address_past_next = 1'b1;
                            end
                            else
                            begin
                                next_address_next = next_address_reg + 8'd1;
                            end
                            bytes_left_next = bytes_left_reg - 8'd1;
                            if (bytes_left_reg == 8'd1)
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        default:
                        begin
                            phase_next = (s_tdata == SYNC_BYTE) ? PH_HEADER : PH_HUNT;
                        end
                    endcase
                end
            end
            CTL_RD_ADDR:
            begin
                ctl_next = CTL_RD_DATA;
            end
            CTL_RD_DATA:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = (mem_rvalid_reg && (rd_addr_reg < REG_COUNT_EXT))
                                    ? mem_rdata_reg : 8'd0;
                    m_tlast_next  = (rd_count_reg == LEN_W'(1));
                    rd_count_next = rd_count_reg - LEN_W'(1);
                    rd_addr_next  = rd_addr_reg + 9'd1;
                    ctl_next      = (rd_count_reg == LEN_W'(1)) ? CTL_IDLE : CTL_RD_ADDR;
                end
            end
            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_identity_reg <= ID_RESET;
            phase_reg           <= PH_HUNT;
            write_mode_reg      <= 1'b0;
            next_address_reg    <= 8'd0;
            address_past_reg    <= 1'b0;
            bytes_left_reg      <= 8'd0;
            ctl_reg             <= CTL_IDLE;
            rd_addr_reg         <= 9'd0;
            rd_count_reg        <= '0;
            m_tvalid_reg        <= 1'b0;
            entry_valid_reg     <= '0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == ADDR_DEVICE_IDENTITY[2]))
            begin
                device_identity_reg <= pwdata[6:0];
            end
            phase_reg        <= phase_next;
            write_mode_reg   <= write_mode_next;
            next_address_reg <= next_address_next;
            address_past_reg <= address_past_next;
            bytes_left_reg   <= bytes_left_next;
            ctl_reg          <= ctl_next;
            rd_addr_reg      <= rd_addr_next;
            rd_count_reg     <= rd_count_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (mem_we)
            begin
                entry_valid_reg[next_address_reg[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // register memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[next_address_reg[ADDR_W-1:0]] <= s_tdata;
        end
        mem_rdata_reg  <= mem[rd_addr_reg[ADDR_W-1:0]];
        mem_rvalid_reg <= entry_valid_reg[rd_addr_reg[ADDR_W-1:0]];
    end

    a_reply_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg != CTL_IDLE) |-> (rd_count_reg != '0))
        else $error("reply sequencer active with no bytes left");

    a_reply_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == CTL_RD_DATA) && out_free |=> m_tvalid_reg)
        else $error("reply byte not loaded into output register");

    a_write_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (phase_reg == PH_WDATA) && (bytes_left_reg == 8'd1)
        |=> (phase_reg == PH_HUNT))
        else $error("write frame did not end after its last data byte");

    a_last_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == CTL_RD_DATA) && out_free && (rd_count_reg == LEN_W'(1))
        |=> (ctl_reg == CTL_IDLE) && m_tlast_reg)
        else $error("final reply byte not marked or sequencer not idle");

endmodule : byte_framed_register_access_slave_unit
`default_nettype wire
